// File: hdl/sbf_pkg.sv
// Shared types, codes and the CRC helper for the block framer.
package sbf_pkg;

  // event codes
  localparam logic [2:0] EV_PAYLOAD  = 3'd0;
  localparam logic [2:0] EV_GOOD     = 3'd1;
  localparam logic [2:0] EV_CRC_BAD  = 3'd2;
  localparam logic [2:0] EV_BAD_LEN  = 3'd3;
  localparam logic [2:0] EV_OVERSIZE = 3'd4;
  localparam logic [2:0] EV_RESP_OK  = 3'd5;
  localparam logic [2:0] EV_RESP_BAD = 3'd6;

  // configuration register indexes
  localparam logic CFG_SYNC_FIRST  = 1'b0;
  localparam logic CFG_SYNC_SECOND = 1'b1;

  localparam logic [7:0] SYNC_FIRST_RST  = 8'h24;
  localparam logic [7:0] SYNC_SECOND_RST = 8'h40;

  localparam logic [7:0] CH_RESP  = 8'h52;  // 'R'
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;

  localparam logic [15:0] HDR_LEN   = 16'd8;
  localparam logic [15:0] LEN_ALIGN = 16'd3;
  localparam logic [15:0] CRC_POLY  = 16'h1021;

  // result queue geometry
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef struct packed {
    logic [2:0]  ev;
    logic [7:0]  data;
    logic [15:0] idx;
    logic [15:0] id;
    logic [15:0] len;
    logic [31:0] err;
    logic        last;
  } rec_t;

  // up to two results per received byte
  typedef struct packed {
    logic [1:0] cnt;
    rec_t       r0;
    rec_t       r1;
  } push_t;

  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) c = {c[14:0], 1'b0} ^ CRC_POLY;
      else       c = {c[14:0], 1'b0};
    end
    return c;
  endfunction

  function automatic rec_t mk_rec(input logic [2:0] ev, input logic [7:0] data,
                                  input logic [15:0] idx, input logic [15:0] id,
                                  input logic [15:0] len);
    rec_t r;
    r.ev   = ev;
    r.data = data;
    r.idx  = idx;
    r.id   = id;
    r.len  = len;
    r.err  = 32'd0;
    r.last = 1'b0;
    return r;
  endfunction

endpackage

// File: hdl/sbf_block_framer.sv
// A result enters the result queue when its byte is accepted; out_* shows the head.
// Throughput: one byte per cycle while in_ready is high. A frame's final payload byte
// yields a verdict and, below MAX_PAYLOAD, a payload result; they leave the 4-entry
// result queue one at a time. in_ready drops while fewer than two entries are free.
// Reset (synchronous, rst_n low): parser hunts for sync, counters clear, queue empties.
module sbf_block_framer #(
  parameter int MAX_PAYLOAD = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_event_res,
  output logic [7:0]  out_data_byte,
  output logic [15:0] out_byte_index,
  output logic [15:0] out_block_id,
  output logic [15:0] out_frame_length,
  output logic [31:0] out_error_total,
  output logic        out_last
);
  import sbf_pkg::*;

  push_t push;
  rec_t  head;
  logic  take;

  assign take = in_valid && in_ready;

  sbf_parser #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .byte_take (take),
    .rx_byte   (in_rx_byte),
    .push      (push)
  );

  sbf_evq u_evq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .has_room   (in_ready),
    .head_valid (out_valid),
    .head_take  (out_ready),
    .head       (head)
  );

  assign out_event_res    = head.ev;
  assign out_data_byte    = head.data;
  assign out_byte_index   = head.idx;
  assign out_block_id     = head.id;
  assign out_frame_length = head.len;
  assign out_error_total  = head.err;
  assign out_last         = head.last;

endmodule

// File: hdl/sbf_parser.sv
// Front end: sync hunt, header capture, CRC fold and result classification.
module sbf_parser #(
  parameter int MAX_PAYLOAD = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [7:0]          cfg_wdata,
  input  logic                byte_take,
  input  logic [7:0]          rx_byte,
  output sbf_pkg::push_t      push
);
  import sbf_pkg::*;

  localparam logic [3:0] PH_HUNT1  = 4'd0;
  localparam logic [3:0] PH_HUNT2  = 4'd1;
  localparam logic [3:0] PH_CRC_LO = 4'd2;
  localparam logic [3:0] PH_CRC_HI = 4'd3;
  localparam logic [3:0] PH_ID_LO  = 4'd4;
  localparam logic [3:0] PH_ID_HI  = 4'd5;
  localparam logic [3:0] PH_LEN_LO = 4'd6;
  localparam logic [3:0] PH_LEN_HI = 4'd7;
  localparam logic [3:0] PH_DATA   = 4'd8;
  localparam logic [3:0] PH_LINE   = 4'd9;

  localparam logic [15:0] MAX_W    = 16'(MAX_PAYLOAD);
  localparam logic [15:0] MAX_M1_W = 16'(MAX_PAYLOAD - 1);

  logic [7:0]  sync1_r, sync2_r;
  logic [3:0]  phase_r, phase_nxt;
  logic [15:0] count_r, count_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [15:0] rcrc_r, rcrc_nxt;
  logic [15:0] id_r, id_nxt;
  logic [15:0] len_r, len_nxt;
  logic [31:0] err_r, err_nxt;
  logic        colon_r, colon_nxt;

  logic [15:0] crc_fed;
  logic [15:0] count_inc;
  logic [15:0] pay_len;
  logic        a_en, b_en;
  rec_t        a_rec, b_rec, r0, r1;

  assign crc_fed   = crc_fold((phase_r == PH_ID_LO) ? 16'd0 : crc_r, rx_byte);
  assign count_inc = count_r + 16'd1;
  assign pay_len   = len_r - HDR_LEN;

  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    crc_nxt   = crc_r;
    rcrc_nxt  = rcrc_r;
    id_nxt    = id_r;
    len_nxt   = len_r;
    err_nxt   = err_r;
    colon_nxt = colon_r;
    a_en      = 1'b0;
    b_en      = 1'b0;
    a_rec     = mk_rec(EV_PAYLOAD, rx_byte, count_r, id_r, len_r);
    b_rec     = mk_rec(EV_PAYLOAD, 8'd0, 16'd0, id_r, len_r);
    unique case (phase_r)
      PH_HUNT2: begin
        if (rx_byte == sync2_r)      phase_nxt = PH_CRC_LO;
        else if (rx_byte == CH_RESP) phase_nxt = PH_LINE;
        else                         phase_nxt = PH_HUNT1;
      end
      PH_CRC_LO: begin
        rcrc_nxt  = {8'd0, rx_byte};
        phase_nxt = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        rcrc_nxt  = {rx_byte, rcrc_r[7:0]};
        phase_nxt = PH_ID_LO;
      end
      PH_ID_LO: begin
        id_nxt    = {8'd0, rx_byte};
        crc_nxt   = crc_fed;
        phase_nxt = PH_ID_HI;
      end
      PH_ID_HI: begin
        id_nxt    = {rx_byte, id_r[7:0]};
        crc_nxt   = crc_fed;
        phase_nxt = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        len_nxt   = {8'd0, rx_byte};
        crc_nxt   = crc_fed;
        phase_nxt = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        len_nxt   = {rx_byte, len_r[7:0]};
        crc_nxt   = crc_fed;
        count_nxt = 16'd0;
        b_rec     = mk_rec(EV_BAD_LEN, 8'd0, 16'd0, id_r, len_nxt);
        phase_nxt = PH_HUNT1;
        if (len_nxt < HDR_LEN) begin
          err_nxt = err_r + 32'd1;
          b_en    = 1'b1;
        end else if ((len_nxt & LEN_ALIGN) != 16'd0) begin
          b_en = 1'b1;
        end else if (len_nxt == HDR_LEN) begin
          // header-only frame: verdict right away
          b_en = 1'b1;
          if (rcrc_r == crc_fed) begin
            b_rec.ev = EV_GOOD;
          end else begin
            b_rec.ev = EV_CRC_BAD;
            err_nxt  = err_r + 32'd1;
          end
        end else begin
          phase_nxt = PH_DATA;
        end
      end
      PH_DATA: begin
        a_en      = (count_r < MAX_W);
        crc_nxt   = crc_fed;
        count_nxt = count_inc;
        b_rec     = mk_rec(EV_GOOD, 8'd0, pay_len, id_r, len_r);
        if (count_inc >= pay_len) begin
          b_en      = 1'b1;
          phase_nxt = PH_HUNT1;
          if (count_inc > MAX_W) begin
            b_rec.ev = EV_OVERSIZE;
          end else if (rcrc_r != crc_fed) begin
            b_rec.ev = EV_CRC_BAD;
            err_nxt  = err_r + 32'd1;
          end
        end
      end
      PH_LINE: begin
        b_rec = mk_rec(EV_RESP_BAD, 8'd0, count_inc, 16'd0, 16'd0);
        if (count_r >= MAX_M1_W) begin
          // overlong line is dropped silently
          phase_nxt = PH_HUNT1;
        end else begin
          if (count_r == 16'd0) colon_nxt = (rx_byte == CH_COLON);
          count_nxt = count_inc;
          if (rx_byte == CH_NL) begin
            b_en      = 1'b1;
            phase_nxt = PH_HUNT1;
            if ((count_r == 16'd0) ? (rx_byte == CH_COLON) : colon_r) b_rec.ev = EV_RESP_OK;
          end
        end
      end
      default: begin
        phase_nxt = PH_HUNT1;
        if (rx_byte == sync1_r) begin
          phase_nxt = PH_HUNT2;
          count_nxt = 16'd0;
        end
      end
    endcase
  end

  always_comb begin
    r0      = a_en ? a_rec : b_rec;
    r1      = b_rec;
    r0.err  = err_nxt;
    r1.err  = err_nxt;
    r0.last = !(a_en && b_en);
    r1.last = 1'b1;
    push.r0  = r0;
    push.r1  = r1;
    push.cnt = byte_take ? ({1'b0, a_en} + {1'b0, b_en}) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync1_r <= SYNC_FIRST_RST;
      sync2_r <= SYNC_SECOND_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_SYNC_FIRST) sync1_r <= cfg_wdata;
      if (cfg_index == CFG_SYNC_SECOND) sync2_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT1;
      count_r <= 16'd0;
      crc_r   <= 16'd0;
      rcrc_r  <= 16'd0;
      id_r    <= 16'd0;
      len_r   <= 16'd0;
      err_r   <= 32'd0;
      colon_r <= 1'b0;
    end else if (byte_take) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      crc_r   <= crc_nxt;
      rcrc_r  <= rcrc_nxt;
      id_r    <= id_nxt;
      len_r   <= len_nxt;
      err_r   <= err_nxt;
      colon_r <= colon_nxt;
    end
  end

endmodule

// File: hdl/sbf_evq.sv
// Back end: result queue taking up to two entries per cycle, draining one.
module sbf_evq (
  input  logic           clk,
  input  logic           rst_n,
  input  sbf_pkg::push_t push,
  output logic           has_room,
  output logic           head_valid,
  input  logic           head_take,
  output sbf_pkg::rec_t  head
);
  import sbf_pkg::*;

  rec_t              q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              pop;

  // room for the worst case of two results from one byte
  assign has_room   = (cnt_r <= QCNT_W'(QDEPTH - 2));
  assign head_valid = (cnt_r != '0);
  assign pop        = head_valid && head_take;
  assign head       = q_r[rd_ptr_r];
  assign cnt_nxt    = cnt_r + QCNT_W'(push.cnt) - QCNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) q_r[wr_ptr_r] <= push.r0;
    if (push.cnt == 2'd2) q_r[wr_ptr_r + QPTR_W'(1)] <= push.r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + QPTR_W'(push.cnt);
      rd_ptr_r <= rd_ptr_r + QPTR_W'(pop);
      cnt_r    <= cnt_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH)) else $error("result queue count out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt != 2'd0) |-> has_room) else $error("push into full result queue");

  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r - rd_ptr_r) == cnt_r[QPTR_W-1:0]) else $error("queue pointers disagree with count");

  a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && push.cnt == 2'd0) |=> (cnt_r == $past(cnt_r) - QCNT_W'(1)))
    else $error("queue count did not drop on pop");

endmodule

// File: tb/tb.sv
// Self-checking testbench for sbf_block_framer: directed and random byte streams vs a predictor.
module tb;
  import sbf_pkg::*;

  localparam int MAXP  = 256;
  localparam int LIMIT = 400000;

  typedef enum logic [3:0] {
    PH_HUNT1, PH_HUNT2, PH_CRC_LO, PH_CRC_HI, PH_ID_LO,
    PH_ID_HI, PH_LEN_LO, PH_LEN_HI, PH_DATA, PH_LINE
  } parse_phase_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [7:0]  cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_event_res;
  logic [7:0]  out_data_byte;
  logic [15:0] out_byte_index;
  logic [15:0] out_block_id;
  logic [15:0] out_frame_length;
  logic [31:0] out_error_total;
  logic        out_last;

  sbf_block_framer #(.MAX_PAYLOAD(MAXP)) DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_rx_byte(in_rx_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_event_res(out_event_res), .out_data_byte(out_data_byte),
    .out_byte_index(out_byte_index), .out_block_id(out_block_id),
    .out_frame_length(out_frame_length), .out_error_total(out_error_total),
    .out_last(out_last)
  );

  // predictor state
  parse_phase_t rx_phase;
  logic [15:0]  pay_cnt;
  logic [15:0]  crc_calc;
  logic [15:0]  crc_recv;
  logic [15:0]  blk_id;
  logic [15:0]  blk_len;
  logic [31:0]  err_tally;
  logic         line_colon;
  logic [7:0]   sync_a;
  logic [7:0]   sync_b;

  rec_t expected_events[$];
  int   mismatches = 0;
  int   items_sent;
  int   cycles = 0;
  int   snd_idle;
  int   rcv_idle;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] d);
    logic [15:0] r;
    logic        fb;
    r = acc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ d[i];
      r  = {r[14:0], 1'b0};
      if (fb) r = r ^ CRC_POLY;
    end
    return r;
  endfunction

  function automatic rec_t make_event(input logic [2:0] ev, input logic [7:0] data,
                                      input logic [15:0] idx, input logic [15:0] id,
                                      input logic [15:0] len);
    rec_t r;
    r.ev   = ev;
    r.data = data;
    r.idx  = idx;
    r.id   = id;
    r.len  = len;
    r.err  = 32'd0;
    r.last = 1'b0;
    return r;
  endfunction

  function logic [2:0] crc_verdict();
    if (crc_recv == crc_calc) return EV_GOOD;
    err_tally = err_tally + 32'd1;
    return EV_CRC_BAD;
  endfunction

  task automatic reset_model();
    rx_phase   = PH_HUNT1;
    pay_cnt    = '0;
    crc_calc   = '0;
    crc_recv   = '0;
    blk_id     = '0;
    blk_len    = '0;
    err_tally  = '0;
    line_colon = 1'b0;
    sync_a     = SYNC_FIRST_RST;
    sync_b     = SYNC_SECOND_RST;
  endtask

  // advance the framer state by one accepted byte and queue what it should emit
  task automatic predict_framer(input logic [7:0] b);
    rec_t fresh[$];
    case (rx_phase)
      PH_HUNT2: begin
        if (b == sync_b) rx_phase = PH_CRC_LO;
        else if (b == CH_RESP) rx_phase = PH_LINE;
        else rx_phase = PH_HUNT1;
      end
      PH_CRC_LO: begin
        crc_recv = {8'h00, b};
        rx_phase = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        crc_recv[15:8] = b;
        rx_phase = PH_ID_LO;
      end
      PH_ID_LO: begin
        blk_id   = {8'h00, b};
        crc_calc = crc_step(16'h0000, b);
        rx_phase = PH_ID_HI;
      end
      PH_ID_HI: begin
        blk_id[15:8] = b;
        crc_calc = crc_step(crc_calc, b);
        rx_phase = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        blk_len  = {8'h00, b};
        crc_calc = crc_step(crc_calc, b);
        rx_phase = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        blk_len[15:8] = b;
        crc_calc = crc_step(crc_calc, b);
        pay_cnt  = '0;
        if (blk_len < HDR_LEN) begin
          err_tally = err_tally + 32'd1;
          fresh.push_back(make_event(EV_BAD_LEN, 8'h00, 16'h0, blk_id, blk_len));
          rx_phase = PH_HUNT1;
        end else if ((blk_len & LEN_ALIGN) != 16'h0) begin
          fresh.push_back(make_event(EV_BAD_LEN, 8'h00, 16'h0, blk_id, blk_len));
          rx_phase = PH_HUNT1;
        end else if (blk_len == HDR_LEN) begin
          fresh.push_back(make_event(crc_verdict(), 8'h00, 16'h0, blk_id, blk_len));
          rx_phase = PH_HUNT1;
        end else begin
          rx_phase = PH_DATA;
        end
      end
      PH_DATA: begin
        if (pay_cnt < MAXP)
          fresh.push_back(make_event(EV_PAYLOAD, b, pay_cnt, blk_id, blk_len));
        crc_calc = crc_step(crc_calc, b);
        pay_cnt  = pay_cnt + 16'd1;
        if (pay_cnt >= blk_len - HDR_LEN) begin
          // oversize frames skip the CRC compare and count no error
          fresh.push_back(make_event((pay_cnt > MAXP) ? EV_OVERSIZE : crc_verdict(), 8'h00,
                                     blk_len - HDR_LEN, blk_id, blk_len));
          rx_phase = PH_HUNT1;
        end
      end
      PH_LINE: begin
        if (pay_cnt >= MAXP - 1) begin
          rx_phase = PH_HUNT1;
        end else begin
          if (pay_cnt == 16'h0) line_colon = (b == CH_COLON);
          pay_cnt = pay_cnt + 16'd1;
          if (b == CH_NL) begin
            fresh.push_back(make_event(line_colon ? EV_RESP_OK : EV_RESP_BAD, 8'h00,
                                       pay_cnt, 16'h0, 16'h0));
            rx_phase = PH_HUNT1;
          end
        end
      end
      default: begin
        rx_phase = PH_HUNT1;
        if (b == sync_a) begin
          rx_phase = PH_HUNT2;
          pay_cnt  = '0;
        end
      end
    endcase
    foreach (fresh[k]) begin
      fresh[k].err  = err_tally;
      fresh[k].last = (k == fresh.size() - 1);
      expected_events.push_back(fresh[k]);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  // receiver: random back-pressure and in-order compare
  always @(posedge clk) begin
    rec_t want;
    out_ready <= ($urandom_range(99) >= rcv_idle);
    if (rst_n && out_valid && out_ready) begin
      if (expected_events.size() == 0) begin
        $error("result transaction with nothing expected: event %0d", out_event_res);
        mismatches++;
      end else begin
        want = expected_events.pop_front();
        check_field("event_res", 32'(want.ev), 32'(out_event_res));
        check_field("data_byte", 32'(want.data), 32'(out_data_byte));
        check_field("byte_index", 32'(want.idx), 32'(out_byte_index));
        check_field("block_id", 32'(want.id), 32'(out_block_id));
        check_field("frame_length", 32'(want.len), 32'(out_frame_length));
        check_field("error_total", want.err, out_error_total);
        check_field("last", 32'(want.last), 32'(out_last));
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_framer(b);
    items_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_syncs(input logic [7:0] first, input logic [7:0] second);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SYNC_FIRST;
    cfg_wdata <= first;
    @(posedge clk);
    cfg_index <= CFG_SYNC_SECOND;
    cfg_wdata <= second;
    @(posedge clk);
    cfg_we <= 1'b0;
    sync_a = first;
    sync_b = second;
    @(posedge clk);
  endtask

  // random byte that cannot open a binary header when the parser waits for the second sync
  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    while (rx_phase == PH_HUNT2 && b == sync_b) b = 8'($urandom_range(255));
    return b;
  endfunction

  task automatic realign();
    while (rx_phase != PH_HUNT1) send_byte((rx_phase == PH_LINE) ? CH_NL : noise_byte());
  endtask

  task automatic send_frame(input logic [15:0] id, input logic [15:0] len, input int npay,
                            input bit bad_crc);
    logic [7:0]  body[$];
    logic [7:0]  b;
    logic [15:0] crc;
    crc = crc_step(16'h0000, id[7:0]);
    crc = crc_step(crc, id[15:8]);
    crc = crc_step(crc, len[7:0]);
    crc = crc_step(crc, len[15:8]);
    for (int i = 0; i < npay; i++) begin
      b = 8'($urandom_range(255));
      body.push_back(b);
      crc = crc_step(crc, b);
    end
    if (bad_crc) crc = crc ^ (16'h0001 << $urandom_range(15));
    send_byte(sync_a);
    send_byte(sync_b);
    send_byte(crc[7:0]);
    send_byte(crc[15:8]);
    send_byte(id[7:0]);
    send_byte(id[15:8]);
    send_byte(len[7:0]);
    send_byte(len[15:8]);
    foreach (body[i]) send_byte(body[i]);
  endtask

  task automatic send_line(input int nchar, input bit colon);
    logic [7:0] b;
    send_byte(sync_a);
    send_byte(CH_RESP);
    for (int i = 0; i < nchar; i++) begin
      if (i == 0 && colon) begin
        b = CH_COLON;
      end else begin
        b = 8'($urandom_range(255));
        while (b == CH_NL || (i == 0 && b == CH_COLON)) b = 8'($urandom_range(255));
      end
      send_byte(b);
    end
    send_byte(CH_NL);
  endtask

  task automatic test_directed_frames();
    send_frame(16'h0000, 16'd8, 0, 1'b0);
    send_frame(16'hFFFF, 16'd8, 0, 1'b1);
    send_frame(16'h1234, 16'd12, 4, 1'b0);
    send_frame(16'hABCD, 16'd16, 8, 1'b1);
    send_frame(16'h0F0F, 16'd4, 0, 1'b0);
    send_frame(16'hF0F0, 16'd0, 0, 1'b0);
    send_frame(16'h5555, 16'd13, 0, 1'b0);
    send_frame(16'hAAAA, 16'hFFFF, 0, 1'b0);
    // wrong second byte: the repeated first sync is not taken as a new start
    send_byte(sync_a);
    send_byte(sync_a);
    send_byte(sync_b);
    send_frame(16'h0001, 16'd12, 4, 1'b0);
  endtask

  task automatic test_directed_lines();
    send_line(3, 1'b1);
    send_line(5, 1'b0);
    send_line(0, 1'b0);
    send_line(1, 1'b1);
  endtask

  task automatic test_sync_settings();
    set_syncs(8'h00, 8'hFF);
    send_frame(16'h00FF, 16'd12, 4, 1'b0);
    send_line(2, 1'b1);
    set_syncs(8'hFF, 8'h00);
    send_frame(16'hFF00, 16'd8, 0, 1'b0);
    send_line(2, 1'b0);
    // second sync equal to the response letter: binary block wins
    set_syncs(8'h5A, CH_RESP);
    send_frame(16'h2468, 16'd12, 4, 1'b0);
    set_syncs(SYNC_FIRST_RST, SYNC_SECOND_RST);
  endtask

  task automatic test_size_limits();
    send_frame(16'h1111, 16'(MAXP + 8), MAXP, 1'b0);
    send_frame(16'h3333, 16'(MAXP + 16), MAXP + 8, 1'b1);
    send_line(MAXP - 2, 1'b1);
    // one byte too many: the line is dropped without a result
    send_line(MAXP - 1, 1'b1);
    realign();
  endtask

  task automatic run_random(input int n_items);
    int          stop_at;
    int          pick;
    logic [15:0] len;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 85) realign();
      pick = $urandom_range(99);
      if (pick < 50) begin
        len = 16'(8 + (($urandom_range(99) < 3) ? 4 * $urandom_range(60, 70)
                                                : 4 * $urandom_range(0, 10)));
        send_frame(16'($urandom_range(16'hFFFF)), len, len - 8, $urandom_range(99) < 20);
      end else if (pick < 62) begin
        if ($urandom_range(1)) begin
          len = 16'($urandom_range(7));
        end else begin
          len = 16'($urandom_range(16'hFFFF));
          if ((len & LEN_ALIGN) == 16'h0) len = len | 16'h0001;
        end
        send_frame(16'($urandom_range(16'hFFFF)), len, 0, 1'b0);
      end else if (pick < 72) begin
        // truncated frame: whatever follows is taken as payload
        len = 16'(8 + 4 * $urandom_range(1, 10));
        send_frame(16'($urandom_range(16'hFFFF)), len, $urandom_range(0, len - 9), 1'b0);
      end else if (pick < 88) begin
        send_line($urandom_range(0, 12), $urandom_range(1) == 1);
      end else begin
        repeat ($urandom_range(1, 6)) send_byte(noise_byte());
      end
    end
  endtask

  task automatic test_random_traffic();
    logic [7:0] a;
    logic [7:0] b;
    snd_idle = 14;
    rcv_idle = 49;
    run_random(40);
    a = 8'($urandom_range(255));
    b = 8'($urandom_range(255));
    if (b == CH_RESP) b = b + 8'd1;
    set_syncs(a, b);
    snd_idle = 49;
    rcv_idle = 14;
    run_random(40);
    set_syncs(SYNC_FIRST_RST, SYNC_SECOND_RST);
    snd_idle = 0;
    rcv_idle = 0;
    run_random(40);
  endtask

  initial begin
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = CFG_SYNC_FIRST;
    cfg_wdata  = 8'h00;
    in_valid   = 1'b0;
    in_rx_byte = 8'h00;
    items_sent = 0;
    snd_idle   = 14;
    rcv_idle   = 49;
    reset_model();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_frames();
    test_directed_lines();
    test_sync_settings();
    test_size_limits();
    test_random_traffic();

    drain_results();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
